FILE: src/one_shot_event_timer_table_assert.svh
// Assertion macros for the one-shot event timer table.
`ifndef ONE_SHOT_EVENT_TIMER_TABLE_ASSERT_SVH
`define ONE_SHOT_EVENT_TIMER_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define OSET_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to another one on the following edge.
`define OSET_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define OSET_ASSERT(lbl, clk, rst_n, prop, msg)
`define OSET_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)

`endif

`endif

FILE: src/oset_pkg.sv
// Shared types and constants of the one-shot event timer table.
package oset_pkg;

    localparam int SLOTS = 16;
    localparam int PW    = $clog2(SLOTS + 1);
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_ADD     = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One table entry as held by a cell
    typedef struct packed {
        logic        valid;
        logic [7:0]  event_id;
        logic [31:0] remaining;
    } t_slot;

    localparam t_slot SLOT_EMPTY = '0;

    // Per-cell command from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic dec;
    } t_cell_ctrl;

endpackage

FILE: src/oset_cell.sv
// One cell of the timer table: holds one entry and hands it to its left neighbour.
module oset_cell
    import oset_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctrl  i_ctrl,
    input  t_slot       i_next,
    input  logic [7:0]  i_add_id,
    input  logic [31:0] i_add_delay,
    output t_slot       o_slot,
    output logic        o_zero
);

    logic        r_valid;
    logic [7:0]  r_event_id;
    logic [31:0] r_remaining;

    // Valid flag: set on append, copy from neighbour on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctrl.shift) begin
            r_valid <= i_next.valid;
        end
    end

    // Entry payload: append, shift left or count down
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_event_id  <= i_add_id;
            r_remaining <= i_add_delay;
        end else if (i_ctrl.shift) begin
            r_event_id  <= i_next.event_id;
            r_remaining <= i_next.remaining;
        end else if (i_ctrl.dec) begin
            r_remaining <= r_remaining - 32'd1;
        end
    end

    assign o_slot.valid     = r_valid;
    assign o_slot.event_id  = r_event_id;
    assign o_slot.remaining = r_remaining;
    assign o_zero           = (r_remaining == 32'd0);

endmodule

FILE: src/one_shot_event_timer_table.sv
// One-shot event timer table: a row of entry cells with a scanning sequencer.
//
// Input channel (i_in_valid / o_in_ready) takes one word per item: i_cmd selects
// a tick or an add, i_event_id and i_delay_ticks describe the event to add.
// Output channel (o_out_valid / i_out_ready) gives result words; o_last marks
// the final word of an item. i_cfg_we writes the enable bit from i_cfg_wdata.
// An add or a disabled tick gives one word through a response state, which waits
// for room in the output register. An enabled tick walks the row of cells with a
// pointer, one cell per cycle unless stalled: a surviving entry is counted down,
// an expired entry is reported and the cells to its right shift left by one.
// No new item is taken until the response is given or the walk has ended.
// A stalled receiver holds the walk when a result word cannot be placed in the
// output register; nothing is dropped. Reset empties the table, clears the
// tick counter and the enable bit, and drops any result word.
module one_shot_event_timer_table
    import oset_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_event_id,
    input  logic [31:0] i_delay_ticks,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_fired,
    output logic [7:0]  o_fired_id,
    output logic        o_status,
    output logic [31:0] o_tick_count,
    output logic        o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RESP = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]  r_state, n_state;
    logic        r_enable;
    logic [31:0] r_ticks, n_ticks;
    logic [PW-1:0] r_p, n_p;
    logic        r_resp_status, n_resp_status;
    logic        r_pend, n_pend;
    logic [7:0]  r_pend_id, n_pend_id;

    logic        r_ov;
    logic        r_fired;
    logic [7:0]  r_id;
    logic        r_status;
    logic [31:0] r_tick;
    logic        r_last;

    t_slot       w_slot [SLOTS];
    logic        w_zero [SLOTS];
    logic [SLOTS-1:0] w_valid_vec;
    logic [SLOTS-1:0] w_valid_inc;

    logic        w_in_acc;
    logic        w_can_emit;
    logic        w_add_go;
    logic        w_shift_go;
    logic        w_dec_go;
    logic        w_head_valid;
    logic        w_head_zero;
    logic [7:0]  w_head_id;
    logic        w_emit;
    logic        w_e_fired;
    logic [7:0]  w_e_id;
    logic        w_e_status;
    logic        w_e_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_can_emit = !r_ov || i_out_ready;
    assign w_add_go   = w_in_acc && (i_cmd == CMD_ADD) && !w_valid_vec[SLOTS-1];

    // Build the row of cells; each takes its right neighbour's entry on shift
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        t_cell_ctrl w_ctrl;
        t_slot      w_next;
        logic       w_prev_valid;

        if (i == SLOTS - 1) begin : g_tail
            assign w_next = SLOT_EMPTY;
        end else begin : g_body
            assign w_next = w_slot[i+1];
        end

        if (i == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_valid = w_slot[i-1].valid;
        end

        assign w_ctrl.load  = w_add_go && !w_slot[i].valid && w_prev_valid;
        assign w_ctrl.shift = w_shift_go && (r_p <= PW'(i));
        assign w_ctrl.dec   = w_dec_go && (r_p == PW'(i));
        assign w_valid_vec[i] = w_slot[i].valid;

        oset_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_next      (w_next),
            .i_add_id    (i_event_id),
            .i_add_delay (i_delay_ticks),
            .o_slot      (w_slot[i]),
            .o_zero      (w_zero[i])
        );
    end

    assign w_valid_inc = w_valid_vec + SLOTS'(1);

    // Select the entry under the walk pointer
    always_comb begin
        w_head_valid = 1'b0;
        w_head_zero  = 1'b0;
        w_head_id    = 8'd0;
        if (r_p < PW'(SLOTS)) begin
            w_head_valid = w_slot[r_p[IW-1:0]].valid;
            w_head_zero  = w_zero[r_p[IW-1:0]];
            w_head_id    = w_slot[r_p[IW-1:0]].event_id;
        end
    end

    // Sequencer: accept, answer, walk the table
    always_comb begin
        n_state       = r_state;
        n_ticks       = r_ticks;
        n_p           = r_p;
        n_resp_status = r_resp_status;
        n_pend        = r_pend;
        n_pend_id     = r_pend_id;
        w_shift_go    = 1'b0;
        w_dec_go      = 1'b0;
        w_emit        = 1'b0;
        w_e_fired     = 1'b0;
        w_e_id        = 8'd0;
        w_e_status    = STATUS_OK;
        w_e_last      = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_cmd == CMD_ADD) begin
                        n_resp_status = w_valid_vec[SLOTS-1] ? STATUS_FULL : STATUS_OK;
                        n_state       = ST_RESP;
                    end else if (r_enable) begin
                        n_ticks = r_ticks + 32'd1;
                        n_p     = '0;
                        n_state = ST_SCAN;
                    end else begin
                        n_resp_status = STATUS_OK;
                        n_state       = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (w_can_emit) begin
                    w_emit     = 1'b1;
                    w_e_status = r_resp_status;
                    n_state    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!w_head_valid) begin
                    // End of table: flush the held event, or an empty word, as the final word
                    if (w_can_emit) begin
                        w_emit    = 1'b1;
                        w_e_fired = r_pend;
                        w_e_id    = r_pend ? r_pend_id : 8'd0;
                        n_pend    = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end else if (w_head_zero) begin
                    // Expired: hold it, release the previous one, close the gap
                    if (!r_pend || w_can_emit) begin
                        w_emit     = r_pend;
                        w_e_fired  = 1'b1;
                        w_e_id     = r_pend_id;
                        w_e_last   = 1'b0;
                        n_pend     = 1'b1;
                        n_pend_id  = w_head_id;
                        w_shift_go = 1'b1;
                    end
                end else begin
                    // Still pending: count down and advance
                    w_dec_go = 1'b1;
                    n_p      = r_p + PW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_enable <= 1'b0;
            r_ticks  <= 32'd0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ticks <= n_ticks;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Walk pointer, held status and held event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
        end else begin
            r_p <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_resp_status <= n_resp_status;
        r_pend_id     <= n_pend_id;
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_fired  <= w_e_fired;
            r_id     <= w_e_id;
            r_status <= w_e_status;
            r_tick   <= r_ticks;
            r_last   <= w_e_last;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_fired      = r_fired;
    assign o_fired_id   = r_id;
    assign o_status     = r_status;
    assign o_tick_count = r_tick;
    assign o_last       = r_last;

`include "one_shot_event_timer_table_assert.svh"

    `OSET_ASSERT(a_valid_prefix, i_clk, i_rst_n,
        (w_valid_vec & w_valid_inc) == '0, "table entries not compacted")
    `OSET_ASSERT(a_idle_no_pend, i_clk, i_rst_n,
        (r_state != ST_IDLE) || !r_pend, "held event left behind after walk")
    `OSET_ASSERT(a_ptr_range, i_clk, i_rst_n,
        r_p <= PW'(SLOTS), "walk pointer out of range")
    `OSET_ASSERT_NEXT(a_end_word, i_clk, i_rst_n,
        (r_state == ST_SCAN) && !w_head_valid && w_can_emit,
        o_out_valid && o_last, "walk ended without final word")

endmodule

FILE: tb/tb_one_shot_event_timer_table.sv
// Self-checking testbench for the one-shot event timer table.
`timescale 1ns / 1ps

module tb_one_shot_event_timer_table;
    import oset_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int SETTLE_CYCLES = SLOTS + 8;
    localparam int LONG_HOLD = 300;
    localparam int STALL_LIMIT = 4000;

    // One input word as queued for the driver
    typedef struct packed {
        logic        cmd;
        logic [7:0]  event_id;
        logic [31:0] delay;
    } t_timer_req;

    // One result word as predicted
    typedef struct packed {
        logic        fired;
        logic [7:0]  fired_id;
        logic        status;
        logic [31:0] tick_count;
        logic        last;
    } t_timer_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = CMD_TICK;
    logic [7:0]  i_event_id = 8'd0;
    logic [31:0] i_delay_ticks = 32'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_fired;
    logic [7:0]  o_fired_id;
    logic        o_status;
    logic [31:0] o_tick_count;
    logic        o_last;

    one_shot_event_timer_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_event_id    (i_event_id),
        .i_delay_ticks (i_delay_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fired       (o_fired),
        .o_fired_id    (o_fired_id),
        .o_status      (o_status),
        .o_tick_count  (o_tick_count),
        .o_last        (o_last)
    );

    // Words waiting to be offered, and result words still owed by the block
    t_timer_req  req_backlog[$];
    t_timer_word expected_words[$];

    // Shadow of the event table, tick counter and enable bit
    t_slot       sched[SLOTS];
    logic [31:0] tick_ctr = 32'd0;
    logic        tick_en = 1'b0;

    int mismatches = 0;
    int n_adds = 0;
    int n_full = 0;
    int n_ticks_on = 0;
    int n_ticks_off = 0;
    int n_fired = 0;
    int most_fired = 0;
    int words_seen = 0;

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Apply one accepted word to the shadow table and queue the words it owes
    task automatic advance_timer_table(input logic cmd, input logic [7:0] id,
                                       input logic [31:0] delay);
        t_timer_word w;
        t_timer_word held;
        logic        have_held;
        logic        placed;
        int          keep;
        int          nfired;
        w = '0;
        w.last = 1'b1;
        w.tick_count = tick_ctr;
        if (cmd == CMD_ADD) begin
            n_adds++;
            placed = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!placed && !sched[i].valid) begin
                    sched[i].valid = 1'b1;
                    sched[i].event_id = id;
                    sched[i].remaining = delay;
                    placed = 1'b1;
                end
            end
            w.status = placed ? STATUS_OK : STATUS_FULL;
            if (!placed)
                n_full++;
            expected_words.push_back(w);
        end else if (!tick_en) begin
            n_ticks_off++;
            expected_words.push_back(w);
        end else begin
            n_ticks_on++;
            tick_ctr = tick_ctr + 32'd1;
            keep = 0;
            nfired = 0;
            have_held = 1'b0;
            held = '0;
            // Walk in order: fire expired entries, count down and compact the rest
            for (int i = 0; i < SLOTS; i++) begin
                if (sched[i].valid) begin
                    if (sched[i].remaining == 32'd0) begin
                        if (have_held)
                            expected_words.push_back(held);
                        held = '0;
                        held.fired = 1'b1;
                        held.fired_id = sched[i].event_id;
                        held.status = STATUS_OK;
                        held.tick_count = tick_ctr;
                        have_held = 1'b1;
                        nfired++;
                    end else begin
                        sched[keep].event_id = sched[i].event_id;
                        sched[keep].remaining = sched[i].remaining - 32'd1;
                        sched[keep].valid = 1'b1;
                        keep++;
                    end
                end
            end
            for (int i = keep; i < SLOTS; i++)
                sched[i].valid = 1'b0;
            n_fired += nfired;
            if (nfired > most_fired)
                most_fired = nfired;
            if (have_held) begin
                held.last = 1'b1;
                expected_words.push_back(held);
            end else begin
                w.tick_count = tick_ctr;
                expected_words.push_back(w);
            end
        end
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Driver: offer words from the backlog in bursts with random gaps
    t_timer_req next_req;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_timer_table(i_cmd, i_event_id, i_delay_ticks);
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    next_req = req_backlog.pop_front();
                    i_cmd <= next_req.cmd;
                    i_event_id <= next_req.event_id;
                    i_delay_ticks <= next_req.delay;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word and stall the output on a pattern
    t_timer_word want;
    int hold_left = 0;
    int ready_mode = 0;
    int mode_left = 0;
    bit held_off = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: fired=%0d id=0x%0h status=%0d ticks=%0d",
                           o_fired, o_fired_id, o_status, o_tick_count);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    compare_field("fired", 32'(want.fired), 32'(o_fired));
                    compare_field("fired_id", 32'(want.fired_id), 32'(o_fired_id));
                    compare_field("status", 32'(want.status), 32'(o_status));
                    compare_field("tick_count", want.tick_count, o_tick_count);
                    compare_field("last", 32'(want.last), 32'(o_last));
                end
            end
            // Hold off once for a long stretch while the backlog is deep
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!held_off && words_seen >= 60 && req_backlog.size() >= 20) begin
                held_off = 1'b1;
                hold_left = LONG_HOLD;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: give up when work is pending and no word moves for too long
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (req_backlog.size() == 0 && !i_in_valid && expected_words.size() == 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("** one_shot_event_timer_table: FAILED **");
            $finish;
        end
    end

    task automatic queue_req(input logic cmd, input logic [7:0] id, input logic [31:0] delay);
        t_timer_req r;
        r.cmd = cmd;
        r.event_id = id;
        r.delay = delay;
        req_backlog.push_back(r);
    endtask

    // Queue a stretch of random adds and ticks; ticks carry random payload too
    task automatic queue_random_phase(input int count, input int add_pct);
        int pick;
        logic [31:0] delay;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < add_pct) begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    delay = $urandom;
                else if (pick < 70)
                    delay = $urandom_range(0, 4);
                else
                    delay = $urandom_range(5, 40);
                queue_req(CMD_ADD, 8'($urandom_range(0, 255)), delay);
            end else begin
                queue_req(CMD_TICK, 8'($urandom_range(0, 255)), $urandom);
            end
        end
    endtask

    // Wait until every word has been offered, taken and answered
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_in_valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tick_en = value;
    endtask

    // Sequence the phases of the run
    initial begin
        for (int i = 0; i < SLOTS; i++)
            sched[i] = SLOT_EMPTY;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled: ticks leave the counter alone, adds still land
        write_enable(1'b0);
        queue_req(CMD_TICK, 8'h00, 32'd0);
        queue_req(CMD_ADD, 8'hA5, 32'd0);
        queue_req(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
        wait_drained();

        // Enabled: fill the table, overflow it, then fire in batches
        write_enable(1'b1);
        queue_req(CMD_ADD, 8'h00, 32'd0);
        queue_req(CMD_ADD, 8'hFF, 32'hFFFF_FFFF);
        for (int k = 1; k <= 13; k++)
            queue_req(CMD_ADD, k[7:0], 32'(k % 2));
        queue_req(CMD_ADD, 8'h5A, 32'h8000_0000);
        queue_req(CMD_TICK, 8'h00, 32'd0);
        queue_req(CMD_TICK, 8'h00, 32'd0);
        queue_req(CMD_TICK, 8'h00, 32'd0);
        wait_drained();

        queue_random_phase(80, 50);
        wait_drained();

        write_enable(1'b0);
        queue_random_phase(40, 70);
        wait_drained();

        write_enable(1'b1);
        queue_random_phase(80, 35);
        wait_drained();

        queue_random_phase(80, 65);
        wait_drained();

        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            mismatches++;
        end
        $display("Covered %0d adds (%0d refused on a full table), %0d enabled and %0d %s",
                 n_adds, n_full, n_ticks_on, n_ticks_off, "disabled ticks.");
        $display("Checked %0d words; %0d events fired, up to %0d in one tick; counter at %0d.",
                 words_seen, n_fired, most_fired, tick_ctr);
        if (mismatches == 0) begin
            $display("** one_shot_event_timer_table: PASSED **");
        end else begin
            $display("** one_shot_event_timer_table: FAILED **");
        end
        $finish;
    end

endmodule
